/* rtl/mcg_pkg.sv */
// Package for the midpoint circle generator.
// Holds the request codes, register indexes, constants and shared structs.
// No dependencies; the stepper, emitter and top level refer to it by scoped names.
package mcg_pkg;

   typedef enum logic {
      REQ_START   = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_SCREEN_MAX_X = 1'b0,
      CSR_SCREEN_MAX_Y = 1'b1
   } csr_index_type;

   localparam logic [7:0]  SCREEN_MAX_X_RESET = 8'd127;
   localparam logic [7:0]  SCREEN_MAX_Y_RESET = 8'd63;
   localparam logic [11:0] DEC_START_BIAS     = 12'd3;
   localparam logic [11:0] DEC_STEP_INNER     = 12'd6;
   localparam logic [11:0] DEC_STEP_DIAG      = 12'd10;
   localparam logic [2:0]  LAST_OCTANT        = 3'd7;

   typedef struct packed {
      logic [7:0] max_x;
      logic [7:0] max_y;
   } limits_type;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] off_a;
      logic [7:0] off_b;
      logic       done;
      logic       idle;
   } job_type;

   typedef struct packed {
      logic       busy;
      logic [2:0] octant;
   } emit_status_type;

endpackage

/* rtl/mcg_req_if.sv */
// Request channel of the midpoint circle generator: valid/ready plus payload.
// Standalone; field widths follow the request format.
interface mcg_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] center_x;
   logic [7:0] center_y;
   logic [7:0] radius;

   modport source (output valid, output req_type, output center_x, output center_y,
                   output radius, input ready);
   modport sink   (input valid, input req_type, input center_x, input center_y,
                   input radius, output ready);
endinterface

/* rtl/mcg_rsp_if.sv */
// Response channel of the midpoint circle generator: valid/ready plus one point.
// Standalone; field widths follow the response format.
interface mcg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] point_x;
   logic [7:0] point_y;
   logic       point_valid;
   logic       on_screen;
   logic       last_of_step;
   logic       circle_done;

   modport source (output valid, output point_x, output point_y, output point_valid,
                   output on_screen, output last_of_step, output circle_done,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_valid,
                   input on_screen, input last_of_step, input circle_done,
                   output ready);
endinterface

/* rtl/mcg_stepper.sv */
// Circle state and midpoint step: takes requests and hands one job per request.
// Depends on mcg_pkg and mcg_req_if.
module mcg_stepper (
   input  logic             clock,
   input  logic             reset,
   mcg_req_if.sink          req_bus,
   input  logic             job_ready,
   output mcg_pkg::job_type job,
   output logic             job_load
);

   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [7:0]  off_a_ff, off_a_in;
   logic [7:0]  off_b_ff, off_b_in;
   logic [11:0] decision_ff, decision_in;
   logic        running_ff, running_in;
   logic [11:0] step_diag;
   logic [11:0] step_inner;

   assign req_bus.ready = job_ready;
   assign job_load      = req_bus.valid && job_ready;

   assign step_inner = decision_ff + {2'b00, off_a_ff, 2'b00} + mcg_pkg::DEC_STEP_INNER;
   assign step_diag  = decision_ff + {2'b00, off_a_ff, 2'b00} - {2'b00, off_b_ff, 2'b00}
                       + mcg_pkg::DEC_STEP_DIAG;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      off_a_in    = off_a_ff;
      off_b_in    = off_b_ff;
      decision_in = decision_ff;
      running_in  = running_ff;
      job.idle    = 1'b0;
      if (mcg_pkg::req_kind_type'(req_bus.req_type) == mcg_pkg::REQ_START) begin
         col_in      = req_bus.center_x;
         row_in      = req_bus.center_y;
         off_a_in    = 8'd0;
         off_b_in    = req_bus.radius;
         decision_in = mcg_pkg::DEC_START_BIAS - {3'b000, req_bus.radius, 1'b0};
         running_in  = req_bus.radius != 8'd0;
      end else if (!running_ff) begin
         job.idle = 1'b1;
      end else begin
         if (decision_ff[11]) begin
            decision_in = step_inner;
         end else begin
            decision_in = step_diag;
            off_b_in    = off_b_ff - 8'd1;
         end
         off_a_in   = off_a_ff + 8'd1;
         running_in = off_a_in < off_b_in;
      end
      job.col   = col_in;
      job.row   = row_in;
      job.off_a = off_a_in;
      job.off_b = off_b_in;
      job.done  = !running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= 8'd0;
         row_ff      <= 8'd0;
         off_a_ff    <= 8'd0;
         off_b_ff    <= 8'd0;
         decision_ff <= 12'd0;
         running_ff  <= 1'b0;
      end else if (job_load) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         off_a_ff    <= off_a_in;
         off_b_ff    <= off_b_in;
         decision_ff <= decision_in;
         running_ff  <= running_in;
      end
   end

endmodule

/* rtl/mcg_emitter.sv */
// Job register, octant counter and response register: one point per cycle while the receiver is ready.
// Depends on mcg_pkg and mcg_rsp_if.
module mcg_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  mcg_pkg::limits_type      limits,
   input  mcg_pkg::job_type         job,
   input  logic                     job_load,
   output logic                     job_ready,
   output mcg_pkg::emit_status_type status,
   mcg_rsp_if.source                rsp_bus
);

   mcg_pkg::job_type job_ff;
   logic             job_valid_ff, job_valid_in;
   logic [2:0]       octant_ff, octant_in;
   logic             rsp_valid_ff;
   logic [7:0]       point_x_ff, point_x_in;
   logic [7:0]       point_y_ff, point_y_in;
   logic             point_valid_ff, point_valid_in;
   logic             on_screen_ff, on_screen_in;
   logic             last_ff, last_in;
   logic             done_ff;
   logic             out_load;
   logic [7:0]       x_plus_a, x_plus_b, x_minus_a, x_minus_b;
   logic [7:0]       y_plus_a, y_plus_b, y_minus_a, y_minus_b;

   assign out_load  = job_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign last_in   = job_ff.idle || (octant_ff == mcg_pkg::LAST_OCTANT);
   assign job_ready = !job_valid_ff || (out_load && last_in);

   assign x_plus_a  = job_ff.col + job_ff.off_a;
   assign x_plus_b  = job_ff.col + job_ff.off_b;
   assign x_minus_a = job_ff.col - job_ff.off_a;
   assign x_minus_b = job_ff.col - job_ff.off_b;
   assign y_plus_a  = job_ff.row + job_ff.off_a;
   assign y_plus_b  = job_ff.row + job_ff.off_b;
   assign y_minus_a = job_ff.row - job_ff.off_a;
   assign y_minus_b = job_ff.row - job_ff.off_b;

   always_comb begin
      case (octant_ff)
         3'd0: begin point_x_in = x_plus_b;  point_y_in = y_plus_a;  end
         3'd1: begin point_x_in = x_plus_a;  point_y_in = y_plus_b;  end
         3'd2: begin point_x_in = x_minus_a; point_y_in = y_plus_b;  end
         3'd3: begin point_x_in = x_minus_b; point_y_in = y_plus_a;  end
         3'd4: begin point_x_in = x_minus_b; point_y_in = y_minus_a; end
         3'd5: begin point_x_in = x_minus_a; point_y_in = y_minus_b; end
         3'd6: begin point_x_in = x_plus_a;  point_y_in = y_minus_b; end
         default: begin point_x_in = x_plus_b; point_y_in = y_minus_a; end
      endcase
      point_valid_in = !job_ff.idle;
      if (job_ff.idle) begin
         point_x_in = 8'd0;
         point_y_in = 8'd0;
      end
      on_screen_in = point_valid_in && (point_x_in <= limits.max_x)
                     && (point_y_in <= limits.max_y);
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      octant_in    = octant_ff;
      if (job_load) begin
         job_valid_in = 1'b1;
         octant_in    = 3'd0;
      end else if (out_load) begin
         octant_in = octant_ff + 3'd1;
         if (last_in) begin
            job_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         octant_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         octant_ff    <= octant_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job;
      end
      if (out_load) begin
         point_x_ff     <= point_x_in;
         point_y_ff     <= point_y_in;
         point_valid_ff <= point_valid_in;
         on_screen_ff   <= on_screen_in;
         last_ff        <= last_in;
         done_ff        <= job_ff.done;
      end
   end

   assign status.busy   = job_valid_ff;
   assign status.octant = octant_ff;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.point_x      = point_x_ff;
   assign rsp_bus.point_y      = point_y_ff;
   assign rsp_bus.point_valid  = point_valid_ff;
   assign rsp_bus.on_screen    = on_screen_ff;
   assign rsp_bus.last_of_step = last_ff;
   assign rsp_bus.circle_done  = done_ff;

endmodule

/* rtl/midpoint_circle_generator.sv */
// Top level of the midpoint circle generator: screen limit registers,
// midpoint stepper and point emitter. Depends on mcg_pkg, mcg_req_if,
// mcg_rsp_if, mcg_stepper and mcg_emitter.
//
// Use: a start request (req_type 0) loads centre and radius and yields the
// eight mirrored points of offset (0, radius). Each advance request (req_type 1)
// runs one midpoint step and yields the eight mirrored points of the new
// offsets; circle_done marks the step after which no further step remains.
// An advance with no circle in progress yields one response with
// point_valid low, last_of_step and circle_done high. last_of_step flags the
// final response of every request.
// The first response of a request passes the job register and then the
// response register. Throughput: one response per cycle while the receiver
// is ready; a point request holds the emitter for one response per octant,
// an idle advance for a single response. The next request is accepted in the
// cycle the previous one's last point enters the response register.
// Reset clears the circle state and the channels and restores the screen
// limits to largest column 127 and largest row 63. When the receiver stalls,
// the response register holds its point and the octant counter waits; requests
// stall once the pending job has not yet emitted its last point.
module midpoint_circle_generator (
   input  logic      clock,
   input  logic      reset,
   mcg_req_if.sink   req_bus,
   mcg_rsp_if.source rsp_bus,
   input  logic      csr_write_en,
   input  logic      csr_index,
   input  logic [7:0] csr_wdata
);

   mcg_pkg::limits_type      limits_ff;
   mcg_pkg::job_type         job;
   mcg_pkg::emit_status_type status;
   logic                     job_load;
   logic                     job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_x <= mcg_pkg::SCREEN_MAX_X_RESET;
         limits_ff.max_y <= mcg_pkg::SCREEN_MAX_Y_RESET;
      end else if (csr_write_en) begin
         case (mcg_pkg::csr_index_type'(csr_index))
            mcg_pkg::CSR_SCREEN_MAX_X: limits_ff.max_x <= csr_wdata;
            mcg_pkg::CSR_SCREEN_MAX_Y: limits_ff.max_y <= csr_wdata;
            default: limits_ff <= limits_ff;
         endcase
      end
   end

   mcg_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .job_ready (job_ready),
      .job       (job),
      .job_load  (job_load)
   );

   mcg_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits_ff),
      .job       (job),
      .job_load  (job_load),
      .job_ready (job_ready),
      .status    (status),
      .rsp_bus   (rsp_bus)
   );

   a_idle_result_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.point_valid |-> rsp_bus.last_of_step && rsp_bus.circle_done)
      else $error("idle response without last_of_step and circle_done");

   a_on_screen_needs_point: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.on_screen |-> rsp_bus.point_valid)
      else $error("on_screen set on a response without a point");

   a_accept_starts_job: assert property (@(posedge clock) disable iff (reset)
      job_load |=> status.busy && status.octant == 3'd0)
      else $error("accepted request did not load the emitter");

   a_ready_only_at_end: assert property (@(posedge clock) disable iff (reset)
      status.busy && !job.idle && status.octant != mcg_pkg::LAST_OCTANT
      && !u_emitter.job_ff.idle |-> !job_ready)
      else $error("request accepted before the pending job finished");

endmodule
